[src/ttcpsd_pkg.sv]
package ttcpsd_pkg;

    // Record geometry
    localparam int RECORD_LEN = 512;
    localparam int POS_W      = $clog2(RECORD_LEN + 1);
    localparam int REL_W      = ((POS_W > 11) ? POS_W : 11) + 2;

    // Field widths
    localparam int TIME_W   = 16;
    localparam int DIFF_W   = 17;
    localparam int PED_W    = 18;
    localparam int SAMPLE_W = 14;
    localparam int ACC_W    = 26;
    localparam int RATIO_W  = 14;
    localparam int CNT_W    = 24;
    localparam int GATE_W   = 12;
    localparam int LEAD_W   = 12;
    localparam int OFF_W    = 9;
    localparam int VAL_W    = 19;

    // Divider geometry: 16 quotient bits; quotients beyond the ratio range are clamped
    localparam int QUO_W  = 16;
    localparam int NUM_W  = 40;
    localparam int DEN_W  = ACC_W + 1;
    localparam int DSH_W  = DEN_W + QUO_W - 1;
    localparam int STEP_W = $clog2(QUO_W);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GATE_LEAD    = 3'd0,
        REG_TAIL_OFFSET  = 3'd1,
        REG_END_OFFSET   = 3'd2,
        REG_NEUTRON_LOW  = 3'd3,
        REG_NEUTRON_HIGH = 3'd4,
        REG_PHOTON_LOW   = 3'd5,
        REG_PHOTON_HIGH  = 3'd6
    } cfg_reg_t;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register defaults
    localparam logic [LEAD_W-1:0]        GATE_LEAD_RST    = 12'd320;
    localparam logic [OFF_W-1:0]         TAIL_OFFSET_RST  = 9'd20;
    localparam logic [OFF_W-1:0]         END_OFFSET_RST   = 9'd110;
    localparam logic signed [TIME_W-1:0] NEUTRON_LOW_RST  = 16'sd480;
    localparam logic signed [TIME_W-1:0] NEUTRON_HIGH_RST = 16'sd2400;
    localparam logic signed [TIME_W-1:0] PHOTON_LOW_RST   = -16'sd320;
    localparam logic signed [TIME_W-1:0] PHOTON_HIGH_RST  = 16'sd320;

    localparam logic signed [ACC_W:0] ACC_MAX = 27'sd33554431;
    localparam logic signed [ACC_W:0] ACC_MIN = -27'sd33554432;
    localparam logic [CNT_W-1:0]      CNT_MAX = 24'hFFFFFF;
    localparam logic [QUO_W-1:0]      RATIO_POS_LIM = 16'd8191;
    localparam logic [QUO_W-1:0]      RATIO_NEG_LIM = 16'd8192;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    // Saturating accumulate into the 26 bit signed range
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = ACC_W'(0);
        s = {a[ACC_W-1], a} + {{(ACC_W+1-VAL_W){b[VAL_W-1]}}, b};
        if (s > ACC_MAX)
            return ACC_MAX[ACC_W-1:0];
        else if (s < ACC_MIN)
            return ACC_MIN[ACC_W-1:0];
        else
            return s[ACC_W-1:0];
    endfunction

endpackage

[src/tail_total_charge_psd.sv]
// Tail/total charge pulse shape discrimination, one waveform record at a time.
// Input channel (in_valid/in_ready): op 0 is an event header that places the
// integration gate and latches pedestal, time difference and quality; op 1 is
// a waveform sample. Samples transfer at one per cycle while in_ready is high;
// a sample that is not marked last produces nothing. The sample marked last
// produces one result on the output channel (out_valid/out_ready).
// After the last sample the block holds in_ready low while it finishes the
// event: a setup state, the restoring divider for the tail/total ratio
// (skipped for rejected events or non-positive totals), and a state that
// loads the output register.
// The result sits in an output register; while it waits for out_ready the
// block keeps taking items of the next record. Only a second result stalls
// until the first has transferred.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), used
// while idle. Reset (rst_n low) restores register defaults, clears the
// record, the class counts and the output valid.
module tail_total_charge_psd (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_we,
    input  logic [ttcpsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ttcpsd_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   op,
    input  logic signed [ttcpsd_pkg::TIME_W-1:0]   far_half_time,
    input  logic signed [ttcpsd_pkg::TIME_W-1:0]   near_half_time,
    input  logic [ttcpsd_pkg::PED_W-1:0]           pedestal,
    input  logic                                   far_good,
    input  logic                                   near_good,
    input  logic                                   far_peak_found,
    input  logic                                   near_peak_found,
    input  logic [ttcpsd_pkg::SAMPLE_W-1:0]        sample_value,
    input  logic                                   last_sample,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   event_accepted,
    output logic signed [ttcpsd_pkg::ACC_W-1:0]    total_charge,
    output logic signed [ttcpsd_pkg::ACC_W-1:0]    tail_charge,
    output logic signed [ttcpsd_pkg::RATIO_W-1:0]  tail_ratio,
    output logic                                   ratio_invalid,
    output logic                                   is_neutron,
    output logic                                   is_photon,
    output logic [ttcpsd_pkg::CNT_W-1:0]           neutron_count,
    output logic [ttcpsd_pkg::CNT_W-1:0]           photon_count
);
    import ttcpsd_pkg::*;

    // Configuration registers
    logic [LEAD_W-1:0]        gate_lead_reg;
    logic [OFF_W-1:0]         tail_offset_reg;
    logic [OFF_W-1:0]         end_offset_reg;
    logic signed [TIME_W-1:0] neutron_low_reg;
    logic signed [TIME_W-1:0] neutron_high_reg;
    logic signed [TIME_W-1:0] photon_low_reg;
    logic signed [TIME_W-1:0] photon_high_reg;

    // Record state
    state_t                   state_reg, state_next;
    logic signed [GATE_W-1:0] gate_reg, gate_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic signed [ACC_W-1:0]  total_reg, total_next;
    logic signed [ACC_W-1:0]  tail_reg, tail_next;
    logic                     ok_reg, ok_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [PED_W-1:0]         ped_reg, ped_next;
    logic [CNT_W-1:0]         ncnt_reg, ncnt_next;
    logic [CNT_W-1:0]         pcnt_reg, pcnt_next;

    // Divider state
    logic [NUM_W-1:0]         rem_reg, rem_next;
    logic [DSH_W-1:0]         dsh_reg, dsh_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [STEP_W-1:0]        step_reg, step_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic                     acc_out_reg;
    logic signed [ACC_W-1:0]  tot_out_reg;
    logic signed [ACC_W-1:0]  tail_out_reg;
    logic signed [RATIO_W-1:0] ratio_out_reg;
    logic                     inval_out_reg;
    logic                     isn_out_reg;
    logic                     isp_out_reg;

    // Handshake and control
    logic                     in_xfer;
    logic                     out_load;
    logic                     hdr_xfer;
    logic                     smp_xfer;

    // Header datapath
    logic signed [DIFF_W:0]   gate_sum;
    logic signed [DIFF_W-4:0] gate_ns;
    logic signed [DIFF_W-3:0] gate_ns_inc;

    // Sample datapath
    logic signed [REL_W-1:0]  rel_pos;
    logic signed [VAL_W-1:0]  contrib;
    logic [OFF_W-1:0]         win_hi;
    logic                     in_total;
    logic                     in_tail;

    // Divider datapath
    logic [ACC_W-1:0]         tail_mag;
    logic [DSH_W-1:0]         rem_ext;
    logic                     quo_bit;
    logic                     tot_pos;

    // Result datapath
    logic                     res_isn;
    logic                     res_isp;
    logic signed [RATIO_W-1:0] res_ratio;

    assign in_xfer  = in_valid && in_ready;
    assign hdr_xfer = in_xfer && (op == OP_HEADER);
    assign smp_xfer = in_xfer && (op == OP_SAMPLE);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_lead_reg    <= GATE_LEAD_RST;
            tail_offset_reg  <= TAIL_OFFSET_RST;
            end_offset_reg   <= END_OFFSET_RST;
            neutron_low_reg  <= NEUTRON_LOW_RST;
            neutron_high_reg <= NEUTRON_HIGH_RST;
            photon_low_reg   <= PHOTON_LOW_RST;
            photon_high_reg  <= PHOTON_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GATE_LEAD:    gate_lead_reg    <= cfg_data[LEAD_W-1:0];
                REG_TAIL_OFFSET:  tail_offset_reg  <= cfg_data[OFF_W-1:0];
                REG_END_OFFSET:   end_offset_reg   <= cfg_data[OFF_W-1:0];
                REG_NEUTRON_LOW:  neutron_low_reg  <= cfg_data;
                REG_NEUTRON_HIGH: neutron_high_reg <= cfg_data;
                REG_PHOTON_LOW:   photon_low_reg   <= cfg_data;
                REG_PHOTON_HIGH:  photon_high_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Gate start: ceil((far - lead)/16), bumped to even, halved
    assign gate_sum    = {{2{far_half_time[TIME_W-1]}}, far_half_time}
                       - {{(DIFF_W+1-LEAD_W){1'b0}}, gate_lead_reg}
                       + (DIFF_W+1)'(15);
    assign gate_ns     = gate_sum[DIFF_W:4];
    assign gate_ns_inc = {gate_ns[DIFF_W-4], gate_ns} + (DIFF_W-2)'(1);

    // Sample windows and contribution
    assign rel_pos  = $signed({{(REL_W-POS_W){1'b0}}, pos_reg})
                    - {{(REL_W-GATE_W){gate_reg[GATE_W-1]}}, gate_reg};
    assign contrib  = $signed({1'b0, sample_value, 4'b0000}) - $signed({1'b0, ped_reg});
    assign win_hi   = (tail_offset_reg > end_offset_reg) ? tail_offset_reg : end_offset_reg;
    assign in_total = (rel_pos >= 0)
                   && (rel_pos < $signed({{(REL_W-OFF_W){1'b0}}, win_hi}));
    assign in_tail  = (rel_pos >= $signed({{(REL_W-OFF_W){1'b0}}, tail_offset_reg}))
                   && (rel_pos < $signed({{(REL_W-OFF_W){1'b0}}, end_offset_reg}));

    // Divider compare/subtract unit
    assign tail_mag = tail_reg[ACC_W-1] ? ACC_W'(-tail_reg) : ACC_W'(tail_reg);
    assign rem_ext  = {{(DSH_W-NUM_W){1'b0}}, rem_reg};
    assign quo_bit  = (rem_ext >= dsh_reg);
    assign tot_pos  = (total_reg > 0);

    // Result classification and ratio clamp
    assign res_isn = ok_reg && (diff_reg > DIFF_W'(neutron_low_reg))
                           && (diff_reg < DIFF_W'(neutron_high_reg));
    assign res_isp = ok_reg && (diff_reg > DIFF_W'(photon_low_reg))
                           && (diff_reg < DIFF_W'(photon_high_reg));

    always_comb
    begin
        res_ratio = '0;
        if (ok_reg && tot_pos)
        begin
            if (!tail_reg[ACC_W-1])
                res_ratio = (quo_reg > RATIO_POS_LIM) ? RATIO_W'(RATIO_POS_LIM)
                                                      : RATIO_W'(quo_reg);
            else
                res_ratio = (quo_reg > RATIO_NEG_LIM) ? -RATIO_W'(RATIO_NEG_LIM)
                                                      : -RATIO_W'(quo_reg);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (smp_xfer && last_sample)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = (ok_reg && tot_pos) ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    // State machine outputs
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_RUN:  in_ready = 1'b1;
            ST_PREP: ;
            ST_DIV:  ;
            ST_DONE: out_load = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        gate_next  = gate_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        tail_next  = tail_reg;
        ok_next    = ok_reg;
        diff_next  = diff_reg;
        ped_next   = ped_reg;
        ncnt_next  = ncnt_reg;
        pcnt_next  = pcnt_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;

        // header latches the event and opens a new record
        if (hdr_xfer)
        begin
            gate_next  = gate_ns_inc[GATE_W:1];
            diff_next  = {far_half_time[TIME_W-1], far_half_time}
                       - {near_half_time[TIME_W-1], near_half_time};
            ped_next   = pedestal;
            ok_next    = far_good && near_good && far_peak_found && near_peak_found;
            pos_next   = '0;
            total_next = '0;
            tail_next  = '0;
        end

        // sample accumulation inside the record
        if (smp_xfer && (pos_reg < POS_W'(RECORD_LEN)))
        begin
            if (in_total)
                total_next = sat_add(total_reg, contrib);
            if (in_tail)
                tail_next = sat_add(tail_reg, contrib);
            pos_next = pos_reg + POS_W'(1);
        end

        // divider setup: (|tail|*8192 + total) / (2*total)
        if (state_reg == ST_PREP)
        begin
            rem_next  = {{(NUM_W-ACC_W-13){1'b0}}, tail_mag, 13'b0}
                      + {{(NUM_W-ACC_W){1'b0}}, total_reg};
            dsh_next  = {total_reg, 1'b0, {(QUO_W-1){1'b0}}};
            quo_next  = '0;
            step_next = STEP_W'(QUO_W - 1);
        end

        // one quotient bit per cycle
        if (state_reg == ST_DIV)
        begin
            if (quo_bit)
                rem_next = rem_reg - dsh_reg[NUM_W-1:0];
            quo_next  = {quo_reg[QUO_W-2:0], quo_bit};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - STEP_W'(1);
        end

        // result load: bump counts, close the record
        if (out_load)
        begin
            if (res_isn && (ncnt_reg < CNT_MAX))
                ncnt_next = ncnt_reg + CNT_W'(1);
            if (res_isp && (pcnt_reg < CNT_MAX))
                pcnt_next = pcnt_reg + CNT_W'(1);
            pos_next   = '0;
            total_next = '0;
            tail_next  = '0;
            ok_next    = 1'b0;
        end
    end

    // State, record and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            gate_reg  <= '0;
            pos_reg   <= '0;
            total_reg <= '0;
            tail_reg  <= '0;
            ok_reg    <= 1'b0;
            diff_reg  <= '0;
            ped_reg   <= '0;
            ncnt_reg  <= '0;
            pcnt_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            gate_reg  <= gate_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            tail_reg  <= tail_next;
            ok_reg    <= ok_next;
            diff_reg  <= diff_next;
            ped_reg   <= ped_next;
            ncnt_reg  <= ncnt_next;
            pcnt_reg  <= pcnt_next;
            step_reg  <= step_next;
        end
    end

    // Divider payload registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            acc_out_reg   <= ok_reg;
            tot_out_reg   <= ok_reg ? total_reg : '0;
            tail_out_reg  <= ok_reg ? tail_reg : '0;
            ratio_out_reg <= res_ratio;
            inval_out_reg <= ok_reg && !tot_pos;
            isn_out_reg   <= res_isn;
            isp_out_reg   <= res_isp;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_accepted = acc_out_reg;
    assign total_charge   = tot_out_reg;
    assign tail_charge    = tail_out_reg;
    assign tail_ratio     = ratio_out_reg;
    assign ratio_invalid  = inval_out_reg;
    assign is_neutron     = isn_out_reg;
    assign is_photon      = isp_out_reg;
    assign neutron_count  = ncnt_reg;
    assign photon_count   = pcnt_reg;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ttcpsd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER = 20;
    localparam int PHASES = 5;
    localparam int DIRECTED_ROWS = 31;

    // One input item as the block sees it; quality = {far_good, near_good, far_peak, near_peak}
    typedef struct packed {
        logic                      op;
        logic signed [TIME_W-1:0]  far;
        logic signed [TIME_W-1:0]  near;
        logic [PED_W-1:0]          ped;
        logic [3:0]                quality;
        logic [SAMPLE_W-1:0]       sample;
        logic                      last;
    } psd_item_t;

    typedef struct packed {
        logic                      accepted;
        logic signed [ACC_W-1:0]   total;
        logic signed [ACC_W-1:0]   tail;
        logic signed [RATIO_W-1:0] ratio;
        logic                      inval;
        logic                      neutron;
        logic                      photon;
        logic [CNT_W-1:0]          n_count;
        logic [CNT_W-1:0]          p_count;
    } psd_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        cfg_reg_t         reg_idx;
        logic [15:0]      reg_val;
        psd_item_t        item;
        logic [9:0]       reps;
        logic             has_result;
        psd_result_t      result;
    } dir_row_t;

    typedef struct packed {
        logic [15:0] lead;
        logic [15:0] tail_off;
        logic [15:0] end_off;
        logic [15:0] n_lo;
        logic [15:0] n_hi;
        logic [15:0] p_lo;
        logic [15:0] p_hi;
    } reg_set_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic op;
    logic signed [TIME_W-1:0] far_half_time;
    logic signed [TIME_W-1:0] near_half_time;
    logic [PED_W-1:0] pedestal;
    logic far_good;
    logic near_good;
    logic far_peak_found;
    logic near_peak_found;
    logic [SAMPLE_W-1:0] sample_value;
    logic last_sample;
    logic out_valid;
    logic out_ready;
    logic event_accepted;
    logic signed [ACC_W-1:0] total_charge;
    logic signed [ACC_W-1:0] tail_charge;
    logic signed [RATIO_W-1:0] tail_ratio;
    logic ratio_invalid;
    logic is_neutron;
    logic is_photon;
    logic [CNT_W-1:0] neutron_count;
    logic [CNT_W-1:0] photon_count;

    // Shadow registers
    int m_lead;
    int m_tail;
    int m_end;
    int m_n_lo;
    int m_n_hi;
    int m_p_lo;
    int m_p_hi;

    // Shadow of the event state
    int gate_idx;
    int rec_pos;
    longint total_sum;
    longint tail_sum;
    bit rec_ok;
    int time_diff;
    int held_ped;
    int n_total;
    int p_total;

    psd_result_t pending_events[$];
    psd_result_t seen_event;
    dir_row_t directed_rows [DIRECTED_ROWS];

    int fails;
    int items_sent;
    int results_seen;
    int cycles;
    int hold_left;
    bit hold_done;
    bit quiet;

    tail_total_charge_psd dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .far_half_time   (far_half_time),
        .near_half_time  (near_half_time),
        .pedestal        (pedestal),
        .far_good        (far_good),
        .near_good       (near_good),
        .far_peak_found  (far_peak_found),
        .near_peak_found (near_peak_found),
        .sample_value    (sample_value),
        .last_sample     (last_sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .event_accepted  (event_accepted),
        .total_charge    (total_charge),
        .tail_charge     (tail_charge),
        .tail_ratio      (tail_ratio),
        .ratio_invalid   (ratio_invalid),
        .is_neutron      (is_neutron),
        .is_photon       (is_photon),
        .neutron_count   (neutron_count),
        .photon_count    (photon_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic longint clamp_acc(input longint x);
        if (x > longint'(ACC_MAX))
            return longint'(ACC_MAX);
        if (x < longint'(ACC_MIN))
            return longint'(ACC_MIN);
        return x;
    endfunction

    // Follow one accepted item through gate placement, integration and classification
    task automatic integrate_pulse(input psd_item_t it);
        int s;
        int n;
        int rel;
        int win_hi;
        int far_i;
        int near_i;
        longint v;
        longint mag;
        longint q;
        longint ratio;
        psd_result_t res;
        if (it.op == OP_HEADER)
        begin
            far_i = $signed(it.far);
            near_i = $signed(it.near);
            s = far_i - m_lead;
            // ceiling to whole ns, bumped to even, then two ns per sample
            n = (s + 65536 + 15) / 16 - 4096;
            if (n % 2 != 0)
                n = n + 1;
            gate_idx = n / 2;
            time_diff = far_i - near_i;
            held_ped = it.ped;
            rec_ok = &it.quality;
            rec_pos = 0;
            total_sum = 0;
            tail_sum = 0;
            return;
        end
        if (rec_pos < RECORD_LEN)
        begin
            rel = rec_pos - gate_idx;
            v = longint'(it.sample) * 16 - longint'(held_ped);
            win_hi = (m_tail > m_end) ? m_tail : m_end;
            if (rel >= 0 && rel < win_hi)
                total_sum = clamp_acc(total_sum + v);
            if (rel >= m_tail && rel < m_end)
                tail_sum = clamp_acc(tail_sum + v);
            rec_pos = rec_pos + 1;
        end
        if (!it.last)
            return;
        res = '0;
        if (rec_ok)
        begin
            res.accepted = 1'b1;
            res.total = total_sum[ACC_W-1:0];
            res.tail = tail_sum[ACC_W-1:0];
            if (total_sum <= 0)
                res.inval = 1'b1;
            else
            begin
                // round to nearest, ties away from zero
                mag = (tail_sum < 0) ? -tail_sum : tail_sum;
                q = (mag * 8192 + total_sum) / (2 * total_sum);
                ratio = (tail_sum < 0) ? -q : q;
                if (ratio > 8191)
                    ratio = 8191;
                if (ratio < -8192)
                    ratio = -8192;
                res.ratio = ratio[RATIO_W-1:0];
            end
            if (time_diff > m_n_lo && time_diff < m_n_hi)
            begin
                res.neutron = 1'b1;
                if (n_total < int'(CNT_MAX))
                    n_total = n_total + 1;
            end
            if (time_diff > m_p_lo && time_diff < m_p_hi)
            begin
                res.photon = 1'b1;
                if (p_total < int'(CNT_MAX))
                    p_total = p_total + 1;
            end
        end
        res.n_count = n_total[CNT_W-1:0];
        res.p_count = p_total[CNT_W-1:0];
        pending_events.push_back(res);
        rec_pos = 0;
        total_sum = 0;
        tail_sum = 0;
        rec_ok = 1'b0;
    endtask

    task automatic compare_event(input psd_result_t want, input psd_result_t got);
        if (got.accepted !== want.accepted)
        begin
            $error("event_accepted: expected %0d, got %0d", want.accepted, got.accepted);
            fails++;
        end
        if (got.total !== want.total)
        begin
            $error("total_charge: expected %0d, got %0d", want.total, got.total);
            fails++;
        end
        if (got.tail !== want.tail)
        begin
            $error("tail_charge: expected %0d, got %0d", want.tail, got.tail);
            fails++;
        end
        if (got.ratio !== want.ratio)
        begin
            $error("tail_ratio: expected %0d, got %0d", want.ratio, got.ratio);
            fails++;
        end
        if (got.inval !== want.inval)
        begin
            $error("ratio_invalid: expected %0d, got %0d", want.inval, got.inval);
            fails++;
        end
        if (got.neutron !== want.neutron)
        begin
            $error("is_neutron: expected %0d, got %0d", want.neutron, got.neutron);
            fails++;
        end
        if (got.photon !== want.photon)
        begin
            $error("is_photon: expected %0d, got %0d", want.photon, got.photon);
            fails++;
        end
        if (got.n_count !== want.n_count)
        begin
            $error("neutron_count: expected %0d, got %0d", want.n_count, got.n_count);
            fails++;
        end
        if (got.p_count !== want.p_count)
        begin
            $error("photon_count: expected %0d, got %0d", want.p_count, got.p_count);
            fails++;
        end
    endtask

    // Result side: check each transfer, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen_event = '{event_accepted, total_charge, tail_charge, tail_ratio,
                               ratio_invalid, is_neutron, is_photon, neutron_count,
                               photon_count};
                if (pending_events.size() == 0)
                begin
                    $error("result transfer with no event pending");
                    fails++;
                end
                else
                    compare_event(pending_events.pop_front(), seen_event);
                results_seen++;
            end
            // one long hold-off so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(0, 99) >= 33);
        end
    end

    // Offer one item and wait for its transfer
    task automatic send_item(input psd_item_t it);
        while (!quiet && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= it.op;
        far_half_time <= it.far;
        near_half_time <= it.near;
        pedestal <= it.ped;
        far_good <= it.quality[3];
        near_good <= it.quality[2];
        far_peak_found <= it.quality[1];
        near_peak_found <= it.quality[0];
        sample_value <= it.sample;
        last_sample <= it.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        integrate_pulse(it);
        items_sent++;
    endtask

    // Wait until every event is out, then let any trailing work settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_GATE_LEAD:    m_lead = int'(val[LEAD_W-1:0]);
            REG_TAIL_OFFSET:  m_tail = int'(val[OFF_W-1:0]);
            REG_END_OFFSET:   m_end = int'(val[OFF_W-1:0]);
            REG_NEUTRON_LOW:  m_n_lo = int'($signed(val));
            REG_NEUTRON_HIGH: m_n_hi = int'($signed(val));
            REG_PHOTON_LOW:   m_p_lo = int'($signed(val));
            REG_PHOTON_HIGH:  m_p_hi = int'($signed(val));
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic dir_row_t hdr(input int far, input int near, input int ped,
                                     input logic [3:0] quality, input logic last);
        dir_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item.op = OP_HEADER;
        r.item.far = 16'(far);
        r.item.near = 16'(near);
        r.item.ped = 18'(ped);
        r.item.quality = quality;
        r.item.last = last;
        r.reps = 10'd1;
        return r;
    endfunction

    function automatic dir_row_t smp(input int val, input int reps, input logic last);
        dir_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item.op = OP_SAMPLE;
        r.item.sample = 14'(val);
        r.item.last = last;
        r.reps = 10'(reps);
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input cfg_reg_t idx, input int val);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = 16'(val);
        return r;
    endfunction

    function automatic dir_row_t with_result(input dir_row_t r, input psd_result_t res);
        r.has_result = 1'b1;
        r.result = res;
        return r;
    endfunction

    // Rejected event: everything zero, counts as they stand
    function automatic psd_result_t rejected(input int nc, input int pc);
        psd_result_t res;
        res = '0;
        res.n_count = nc[CNT_W-1:0];
        res.p_count = pc[CNT_W-1:0];
        return res;
    endfunction

    // One record, mostly well formed with random content, sometimes broken
    task automatic random_record();
        psd_item_t it;
        int kind;
        int len;
        int base;
        int diff;
        int far_i;
        int near_i;
        int sv;
        int k;
        bit wild;
        it = '0;
        kind = $urandom_range(0, 99);
        // stray samples with no header in front
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 3))
            begin
                it.op = OP_SAMPLE;
                it.sample = 14'($urandom_range(0, 16383));
                it.last = 1'($urandom_range(0, 1));
                send_item(it);
            end
            return;
        end
        it.op = OP_HEADER;
        if ($urandom_range(0, 3) != 0)
            far_i = m_lead + int'($urandom_range(0, 1400)) - 700;
        else
            far_i = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 9) < 6)
            diff = int'($urandom_range(0, 3800)) - 800;
        else
            diff = int'($urandom_range(0, 65535)) - 32768;
        near_i = far_i - diff;
        it.far = far_i[TIME_W-1:0];
        it.near = near_i[TIME_W-1:0];
        wild = ($urandom_range(0, 9) < 3);
        base = $urandom_range(0, 2000);
        if (wild)
            it.ped = 18'($urandom_range(0, 262143));
        else
            it.ped = 18'(base * 16 + int'($urandom_range(0, 15)));
        it.quality = ($urandom_range(0, 9) < 8) ? 4'hF : 4'($urandom_range(0, 15));
        it.last = ($urandom_range(0, 7) == 0);
        send_item(it);
        // header alone: the next header overrides it
        if (kind < 20)
            return;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 150) : $urandom_range(1, 12);
        it.op = OP_SAMPLE;
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 99) < 15)
                sv = $urandom_range(0, 16383);
            else
            begin
                sv = base + int'($urandom_range(0, 700)) - 100;
                if (sv < 0)
                    sv = 0;
            end
            it.sample = 14'(sv);
            // truncated records never see a last sample
            it.last = (k == len - 1) && (kind >= 28);
            send_item(it);
        end
    endtask

    initial
    begin
        int i;
        int k;
        int ph;
        int lo;
        int start_items;
        int start_results;
        dir_row_t r;
        psd_item_t it;
        reg_set_t rs;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_GATE_LEAD;
        cfg_data <= '0;
        in_valid <= 1'b0;
        op <= OP_HEADER;
        far_half_time <= '0;
        near_half_time <= '0;
        pedestal <= '0;
        far_good <= 1'b0;
        near_good <= 1'b0;
        far_peak_found <= 1'b0;
        near_peak_found <= 1'b0;
        sample_value <= '0;
        last_sample <= 1'b0;
        out_ready <= 1'b0;

        fails = 0;
        items_sent = 0;
        results_seen = 0;
        cycles = 0;
        hold_left = 0;
        hold_done = 1'b0;
        quiet = 1'b0;

        m_lead = GATE_LEAD_RST;
        m_tail = TAIL_OFFSET_RST;
        m_end = END_OFFSET_RST;
        m_n_lo = NEUTRON_LOW_RST;
        m_n_hi = NEUTRON_HIGH_RST;
        m_p_lo = PHOTON_LOW_RST;
        m_p_hi = PHOTON_HIGH_RST;
        gate_idx = 0;
        rec_pos = 0;
        total_sum = 0;
        tail_sum = 0;
        rec_ok = 1'b0;
        time_diff = 0;
        held_ped = 0;
        n_total = 0;
        p_total = 0;

        directed_rows = '{
            // last sample with no header before it
            with_result(smp(16383, 1, 1'b1), rejected(0, 0)),
            // last flag on a header is ignored
            hdr(0, 0, 0, 4'hF, 1'b1),
            // zero charge: ratio invalid, zero time difference is a photon
            with_result(smp(0, 1, 1'b1),
                        '{1'b1, 26'sd0, 26'sd0, 14'sd0, 1'b1, 1'b0, 1'b1, 24'd0, 24'd1}),
            // each quality flag low on its own
            hdr(-32768, 32767, 262143, 4'b1110, 1'b0),
            with_result(smp(16383, 1, 1'b1), rejected(0, 1)),
            hdr(32767, -32768, 0, 4'b1101, 1'b0),
            with_result(smp(0, 1, 1'b1), rejected(0, 1)),
            hdr(0, 0, 0, 4'b1011, 1'b0),
            with_result(smp(8191, 1, 1'b1), rejected(0, 1)),
            hdr(0, 0, 0, 4'b0111, 1'b0),
            with_result(smp(1, 1, 1'b1), rejected(0, 1)),
            // odd gate count rounded up, neutron time difference
            hdr(1000, 0, 4000, 4'hF, 1'b0),
            smp(1000, 140, 1'b1),
            // gate far ahead of the record
            hdr(-32768, -32168, 0, 4'hF, 1'b0),
            smp(16383, 3, 1'b1),
            cfg_row(REG_GATE_LEAD, 0),
            cfg_row(REG_TAIL_OFFSET, 0),
            cfg_row(REG_END_OFFSET, 511),
            // positive saturation, samples past the record end
            hdr(64, 64, 0, 4'hF, 1'b0),
            smp(16383, 520, 1'b1),
            // negative saturation
            hdr(64, 64, 262143, 4'hF, 1'b0),
            smp(0, 200, 1'b1),
            cfg_row(REG_TAIL_OFFSET, 4),
            cfg_row(REG_END_OFFSET, 8),
            // ratio clipped high
            hdr(0, 0, 8000, 4'hF, 1'b0),
            smp(0, 4, 1'b0),
            smp(1001, 4, 1'b1),
            // ratio clipped low
            hdr(0, 0, 8000, 4'hF, 1'b0),
            smp(1000, 4, 1'b0),
            smp(0, 3, 1'b0),
            smp(500, 1, 1'b1)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            r = directed_rows[i];
            if (r.kind == ROW_CFG)
            begin
                drain();
                write_reg(r.reg_idx, r.reg_val);
                cfg_we <= 1'b0;
            end
            else
            begin
                for (k = 0; k < int'(r.reps); k++)
                begin
                    it = r.item;
                    if (k != int'(r.reps) - 1)
                        it.last = 1'b0;
                    send_item(it);
                end
                if (r.has_result)
                begin
                    void'(pending_events.pop_back());
                    pending_events.push_back(r.result);
                end
            end
        end

        // Random phases, each under its own register setting
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0: rs = '{16'(GATE_LEAD_RST), 16'(TAIL_OFFSET_RST), 16'(END_OFFSET_RST),
                          NEUTRON_LOW_RST, NEUTRON_HIGH_RST, PHOTON_LOW_RST,
                          PHOTON_HIGH_RST};
                1: rs = '{16'd4095, 16'd0, 16'd511, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
                2: rs = '{16'd0, 16'd511, 16'd1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
                default:
                begin
                    lo = $urandom_range(0, 1000);
                    rs.lead = 16'($urandom_range(0, 4095));
                    rs.tail_off = 16'($urandom_range(0, 24));
                    rs.end_off = 16'($urandom_range(1, 40));
                    rs.n_lo = 16'(lo);
                    rs.n_hi = 16'(lo + int'($urandom_range(0, 2500)));
                    rs.p_lo = 16'(-int'($urandom_range(0, 600)));
                    rs.p_hi = 16'($urandom_range(0, 600));
                end
            endcase
            write_reg(REG_GATE_LEAD, rs.lead);
            write_reg(REG_TAIL_OFFSET, rs.tail_off);
            write_reg(REG_END_OFFSET, rs.end_off);
            write_reg(REG_NEUTRON_LOW, rs.n_lo);
            write_reg(REG_NEUTRON_HIGH, rs.n_hi);
            write_reg(REG_PHOTON_LOW, rs.p_lo);
            write_reg(REG_PHOTON_HIGH, rs.p_hi);
            cfg_we <= 1'b0;
            // one phase runs back to back on both sides
            quiet = (ph == 2);
            start_items = items_sent;
            start_results = results_seen;
            while (items_sent - start_items < 80 || results_seen - start_results < 10)
                random_record();
        end

        drain();
        if (fails == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
